// ----- hw/rtl/sle_pkg.sv -----
// Package of the sequential list engine: request, status, state and cell command codes.
// Depends on nothing; used by sle_cell, sle_ctrl and sequential_list_engine.
package sle_pkg;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_LOCATE = 2'd2,
        FN_SORTED = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_SCAN   = 2'd2,
        S_FINISH = 2'd3
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_INSERT     = 3'd1,
        CELL_DELETE     = 3'd2,
        CELL_MARK_EQ    = 3'd3,
        CELL_MARK_GT    = 3'd4,
        CELL_FLAG_SHIFT = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_cmd_t;

    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

endpackage

// ----- hw/rtl/sle_cell.sv -----
// One list cell: holds one entry and one search flag, and trades them with its neighbours.
// Depends on sle_pkg.
module sle_cell #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sle_pkg::cell_cmd_t            cmd,
    input  logic [$clog2(DEPTH)-1:0]      idx,
    input  logic [$clog2(DEPTH+1)-1:0]    count,
    input  logic [DATA_WIDTH-1:0]         value,
    input  logic [DATA_WIDTH-1:0]         left_data,
    input  logic [DATA_WIDTH-1:0]         right_data,
    input  logic                          right_flag,
    output logic [DATA_WIDTH-1:0]         data_out,
    output logic                          flag_out
);

    localparam int IXW = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam logic [IXW-1:0] MY_IDX = IXW'(INDEX);
    localparam logic [CW-1:0]  MY_CNT = CW'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  flag_reg;
    logic                  flag_next;

    always_comb begin
        data_next = data_reg;
        flag_next = flag_reg;
        unique case (cmd.op)
            sle_pkg::CELL_INSERT: begin
                if (MY_IDX == idx) begin
                    data_next = value;
                end else if (MY_IDX > idx) begin
                    data_next = left_data;
                end
            end
            sle_pkg::CELL_DELETE: begin
                if (MY_IDX >= idx) begin
                    data_next = right_data;
                end
            end
            sle_pkg::CELL_MARK_EQ: begin
                flag_next = (MY_CNT < count) && (data_reg == value);
            end
            sle_pkg::CELL_MARK_GT: begin
                flag_next = (MY_CNT >= count) || ($signed(data_reg) > $signed(value));
            end
            sle_pkg::CELL_FLAG_SHIFT: begin
                flag_next = right_flag;
            end
            default: begin
                data_next = data_reg;
                flag_next = flag_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
        end else begin
            flag_reg <= flag_next;
        end
    end

    assign data_out = data_reg;
    assign flag_out = flag_reg;

endmodule

// ----- hw/rtl/sle_ctrl.sv -----
// Request sequencer of the list engine: fill count, search counter, result register.
// Depends on sle_pkg; drives the commands of the sle_cell chain.
module sle_ctrl #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sle_pkg::func_t                s_func,
    input  logic [sle_pkg::POS_W-1:0]     s_position,
    input  logic [sle_pkg::VALUE_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sle_pkg::status_t              m_status,
    output logic [sle_pkg::POS_W-1:0]     m_found_position,
    output logic [sle_pkg::POS_W-1:0]     m_fill_level,
    output sle_pkg::cell_cmd_t            cell_cmd,
    output logic [$clog2(DEPTH)-1:0]      cell_idx,
    output logic [$clog2(DEPTH+1)-1:0]    cell_count,
    output logic [DATA_WIDTH-1:0]         cell_value,
    input  logic                          head_flag
);

    localparam int IXW = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sle_pkg::state_t               state_reg, state_next;
    sle_pkg::func_t                func_reg, func_next;
    logic [sle_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [DATA_WIDTH-1:0]         value_reg, value_next;
    logic [CW-1:0]                 fill_reg, fill_next;
    logic [IXW-1:0]                k_reg, k_next;
    sle_pkg::status_t              res_status_reg, res_status_next;
    logic [sle_pkg::POS_W-1:0]     res_fpos_reg, res_fpos_next;
    logic                          m_valid_reg, m_valid_next;
    sle_pkg::status_t              m_status_reg, m_status_next;
    logic [sle_pkg::POS_W-1:0]     m_fpos_reg, m_fpos_next;
    logic [sle_pkg::POS_W-1:0]     m_fill_reg, m_fill_next;

    logic [PW:0]   pos_ext;
    logic [PW:0]   cnt_ext;
    logic [CW-1:0] k_plus;
    logic          full;

    assign pos_ext = (PW + 1)'(pos_reg);
    assign cnt_ext = (PW + 1)'(fill_reg);
    assign k_plus  = CW'(k_reg) + CW'(1);
    assign full    = (fill_reg == FULL_CNT);

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        fill_next       = fill_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_fpos_next   = res_fpos_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_fpos_next     = m_fpos_reg;
        m_fill_next     = m_fill_reg;
        cell_cmd.op     = sle_pkg::CELL_HOLD;
        cell_idx        = IXW'(pos_ext - (PW + 1)'(1));
        s_ready         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            sle_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next  = s_func;
                    pos_next   = s_position;
                    value_next = DATA_WIDTH'($signed(s_value));
                    state_next = sle_pkg::S_EXEC;
                end
            end
            sle_pkg::S_EXEC: begin
                res_status_next = sle_pkg::ST_OK;
                res_fpos_next   = '0;
                k_next          = '0;
                state_next      = sle_pkg::S_FINISH;
                unique case (func_reg)
                    sle_pkg::FN_INSERT: begin
                        if (full) begin
                            res_status_next = sle_pkg::ST_FULL;
                        end else if (pos_reg == '0 || pos_ext > cnt_ext + (PW + 1)'(1)) begin
                            res_status_next = sle_pkg::ST_BAD_POS;
                        end else begin
                            cell_cmd.op   = sle_pkg::CELL_INSERT;
                            fill_next     = fill_reg + CW'(1);
                            res_fpos_next = pos_reg;
                        end
                    end
                    sle_pkg::FN_DELETE: begin
                        if (pos_reg == '0 || pos_ext > cnt_ext) begin
                            res_status_next = sle_pkg::ST_BAD_POS;
                        end else begin
                            cell_cmd.op = sle_pkg::CELL_DELETE;
                            fill_next   = fill_reg - CW'(1);
                        end
                    end
                    sle_pkg::FN_LOCATE: begin
                        if (fill_reg == '0) begin
                            res_status_next = sle_pkg::ST_NOT_FOUND;
                        end else begin
                            cell_cmd.op = sle_pkg::CELL_MARK_EQ;
                            state_next  = sle_pkg::S_SCAN;
                        end
                    end
                    sle_pkg::FN_SORTED: begin
                        if (full) begin
                            res_status_next = sle_pkg::ST_FULL;
                        end else begin
                            cell_cmd.op = sle_pkg::CELL_MARK_GT;
                            state_next  = sle_pkg::S_SCAN;
                        end
                    end
                    default: begin
                        state_next = sle_pkg::S_FINISH;
                    end
                endcase
            end
            sle_pkg::S_SCAN: begin
                cell_idx = k_reg;
                if (head_flag) begin
                    res_status_next = sle_pkg::ST_OK;
                    res_fpos_next   = sle_pkg::POS_W'(k_plus);
                    state_next      = sle_pkg::S_FINISH;
                    if (func_reg == sle_pkg::FN_SORTED) begin
                        cell_cmd.op = sle_pkg::CELL_INSERT;
                        fill_next   = fill_reg + CW'(1);
                    end
                end else if (func_reg == sle_pkg::FN_LOCATE && k_plus == fill_reg) begin
                    res_status_next = sle_pkg::ST_NOT_FOUND;
                    res_fpos_next   = '0;
                    state_next      = sle_pkg::S_FINISH;
                end else begin
                    cell_cmd.op = sle_pkg::CELL_FLAG_SHIFT;
                    k_next      = k_reg + IXW'(1);
                end
            end
            sle_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_fpos_next   = res_fpos_reg;
                    m_fill_next   = sle_pkg::POS_W'(fill_reg);
                    state_next    = sle_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sle_pkg::S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_fpos_reg   <= res_fpos_next;
        m_status_reg   <= m_status_next;
        m_fpos_reg     <= m_fpos_next;
        m_fill_reg     <= m_fill_next;
    end

    assign cell_count       = fill_reg;
    assign cell_value       = value_reg;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_fpos_reg;
    assign m_fill_level     = m_fill_reg;

    // The list never holds more entries than there are cells.
    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= FULL_CNT)
        else $error("fill count beyond list depth");

    // The search never runs past the last valid entry, or the tail slot for a sorted insert.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sle_pkg::S_SCAN |-> CW'(k_reg) <= fill_reg)
        else $error("search counter beyond fill count");

    // The count moves only while a request is being carried out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sle_pkg::S_IDLE || state_reg == sle_pkg::S_FINISH) |=> $stable(fill_reg))
        else $error("fill count changed outside a request");

    // A full status is only ever reported for a full list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sle_pkg::S_FINISH && res_status_reg == sle_pkg::ST_FULL)
        |-> fill_reg == FULL_CNT)
        else $error("full status with free cells");

endmodule

// ----- hw/rtl/sequential_list_engine.sv -----
// Top level of the sequential list engine: a chain of list cells and its sequencer.
// Depends on sle_pkg, sle_cell and sle_ctrl.
//
// The engine keeps an ordered list of up to DEPTH signed words, one word per cell, and
// takes one request beat at a time. Insert and delete at a position shift the whole
// chain at once in the execute state, and the next beat is accepted only once the
// request has returned to idle. Locate and sorted insert first mark every cell in
// parallel and then move the marks one cell per cycle towards the head of the chain,
// until the search stops at a 0-based position that is at most the fill count. A
// locate on an empty list and a sorted insert into a full list do not search. The
// result waits in an output register, so the next request beat is taken while an
// earlier result is still pending; a request whose result finds that register still
// occupied waits in its finish state until the earlier result beat is taken.
module sequential_list_engine #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // position [6:0], value [38:7], zero [39]
    input  logic [sle_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // func [1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found_position [6:0], fill_level [13:7], zero [15:14]
    output logic [sle_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // status [1:0]
    output logic [1:0]                        m_axis_tuser
);

    localparam int IXW = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);

    sle_pkg::cell_cmd_t              cell_cmd;
    logic [IXW-1:0]                  cell_idx;
    logic [CW-1:0]                   cell_count;
    logic [DATA_WIDTH-1:0]           cell_value;
    logic [DATA_WIDTH-1:0]           cell_data [DEPTH];
    logic                            cell_flag [DEPTH];
    sle_pkg::status_t                m_status;
    logic [sle_pkg::POS_W-1:0]       m_found_position;
    logic [sle_pkg::POS_W-1:0]       m_fill_level;

    sle_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_axis_tvalid),
        .s_ready          (s_axis_tready),
        .s_func           (sle_pkg::func_t'(s_axis_tuser)),
        .s_position       (s_axis_tdata[sle_pkg::POS_W-1:0]),
        .s_value          (s_axis_tdata[sle_pkg::POS_W +: sle_pkg::VALUE_W]),
        .m_valid          (m_axis_tvalid),
        .m_ready          (m_axis_tready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_fill_level     (m_fill_level),
        .cell_cmd         (cell_cmd),
        .cell_idx         (cell_idx),
        .cell_count       (cell_count),
        .cell_value       (cell_value),
        .head_flag        (cell_flag[0])
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;
        logic                  right_flag;

        if (i == 0) begin : g_head
            assign left_data = cell_value;
        end else begin : g_body
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_data = cell_data[i];
            assign right_flag = 1'b0;
        end else begin : g_inner
            assign right_data = cell_data[i+1];
            assign right_flag = cell_flag[i+1];
        end

        sle_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cell_cmd),
            .idx        (cell_idx),
            .count      (cell_count),
            .value      (cell_value),
            .left_data  (left_data),
            .right_data (right_data),
            .right_flag (right_flag),
            .data_out   (cell_data[i]),
            .flag_out   (cell_flag[i])
        );
    end

    assign m_axis_tdata = {2'b00, m_fill_level, m_found_position};
    assign m_axis_tuser = m_status;

endmodule
